>>> rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared constants, command and status codes, and ring address helper for
// the indexed list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

	localparam int DEPTH = 64;
	localparam int DW    = 32;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	// width used for position compares: covers both the count and a 7-bit index
	localparam int XW    = (CW > 7) ? CW : 7;

	typedef enum logic [2:0] {
		CMD_ADD_FRONT = 3'd0,
		CMD_ADD_BACK  = 3'd1,
		CMD_READ      = 3'd2,
		CMD_REMOVE    = 3'd3,
		CMD_SWAP      = 3'd4
	} ile_cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_BAD_INDEX = 2'd1,
		STS_FULL      = 2'd2
	} ile_status_t;

	// map a position onto the ring that starts at base; off stays below DEPTH
	function automatic logic [AW-1:0] phys_addr(logic [AW-1:0] base, logic [XW-1:0] off);
		logic [XW:0] sum;
		sum = (XW+1)'(base) + (XW+1)'(off);
		if (sum >= (XW+1)'(DEPTH)) begin
			sum = sum - (XW+1)'(DEPTH);
		end
		return AW'(sum);
	endfunction

endpackage

`default_nettype wire

>>> rtl/ile_ram.sv
// ----------------------------------------------------------------------------
// ile_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 6,
	parameter int WORDS  = 64
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of up to DEPTH 32-bit values kept in a ring buffer RAM,
// addressed by position; add front/back, read, remove with close-up, swap.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// request   in         start && !busy         cmd, value, index_a, index_b
// result    out        done (one cycle)       data_out, status, count
//
// Add, refused and unused commands: result in the cycle after the request.
// Read: via ST_READ; swap: via ST_SWAP_B/WA/WB (two reads, two writes on the
// single RAM write port); remove at index i: the entries behind i move down one
// place, one entry per cycle through the RAM read/write ports.
// busy is high while a multi-cycle request runs; reset clears count and head.
// Results cannot be stalled; the RAM contents need no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine
	import ile_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  cmd,
	input  wire logic [31:0] value,
	input  wire logic [5:0]  index_a,
	input  wire logic [5:0]  index_b,
	output logic             done,
	output logic [31:0]      data_out,
	output logic [1:0]       status,
	output logic [6:0]       count
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_REMOVE,
		ST_SWAP_B,
		ST_SWAP_WA,
		ST_SWAP_WB
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [XW-1:0]   ia_q;
	logic [XW-1:0]   ib_q;
	logic [XW-1:0]   nxt_q;
	logic            rd_pend_s1;
	logic [XW-1:0]   rd_idx_s1;
	logic [DW-1:0]   tmp_q;
	logic            done_q;
	logic [DW-1:0]   data_q;
	ile_status_t     status_q;
	logic [6:0]      cnt_out_q;

	logic            accept;
	logic [XW-1:0]   ia_x;
	logic [XW-1:0]   ib_x;
	logic [XW-1:0]   cnt_x;
	logic            full;
	logic            ia_bad;
	logic            ib_bad;
	logic [AW-1:0]   head_dec;
	logic            rem_first;
	logic            rem_issue;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [DW-1:0]   ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [DW-1:0]   ram_rdata;

	assign accept    = start && (state_q == ST_IDLE);
	assign ia_x      = XW'(index_a);
	assign ib_x      = XW'(index_b);
	assign cnt_x     = XW'(count_q);
	assign full      = (count_q == CW'(DEPTH));
	assign ia_bad    = (ia_x >= cnt_x);
	assign ib_bad    = (ib_x >= cnt_x);
	assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign rem_first = rd_pend_s1 && (rd_idx_s1 == ia_q);
	assign rem_issue = (nxt_q < cnt_x);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_ADD_FRONT: begin
							ram_we    = !full;
							ram_waddr = head_dec;
							ram_wdata = value;
						end
						CMD_ADD_BACK: begin
							ram_we    = !full;
							ram_waddr = phys_addr(head_q, cnt_x);
							ram_wdata = value;
						end
						CMD_READ, CMD_REMOVE: begin
							ram_re    = !ia_bad;
							ram_raddr = phys_addr(head_q, ia_x);
						end
						CMD_SWAP: begin
							ram_re    = !ia_bad && !ib_bad && (ia_x != ib_x);
							ram_raddr = phys_addr(head_q, ia_x);
						end
						default: begin
						end
					endcase
				end
			end
			ST_REMOVE: begin
				// close up: write the entry fetched last cycle one place lower
				ram_we    = rd_pend_s1 && !rem_first;
				ram_waddr = phys_addr(head_q, rd_idx_s1 - 1'b1);
				ram_wdata = ram_rdata;
				ram_re    = rem_issue;
				ram_raddr = phys_addr(head_q, nxt_q);
			end
			ST_SWAP_B: begin
				ram_re    = 1'b1;
				ram_raddr = phys_addr(head_q, ib_q);
			end
			ST_SWAP_WA: begin
				ram_we    = 1'b1;
				ram_waddr = phys_addr(head_q, ia_q);
				ram_wdata = ram_rdata;
			end
			ST_SWAP_WB: begin
				ram_we    = 1'b1;
				ram_waddr = phys_addr(head_q, ib_q);
				ram_wdata = tmp_q;
			end
			default: begin
			end
		endcase
	end

	ile_ram #(
		.DATA_W (DW),
		.ADDR_W (AW),
		.WORDS  (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			rd_pend_s1 <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= STS_OK;
			cnt_out_q  <= '0;
			data_q     <= '0;
		end else begin
			done_q     <= 1'b0;
			rd_pend_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ia_q      <= ia_x;
						ib_q      <= ib_x;
						data_q    <= '0;
						status_q  <= STS_OK;
						cnt_out_q <= 7'(count_q);
						case (cmd)
							CMD_ADD_FRONT, CMD_ADD_BACK: begin
								done_q <= 1'b1;
								if (full) begin
									status_q <= STS_FULL;
								end else begin
									count_q   <= count_q + 1'b1;
									cnt_out_q <= 7'(count_q + 1'b1);
									if (cmd == CMD_ADD_FRONT) begin
										head_q <= head_dec;
									end
								end
							end
							CMD_READ: begin
								if (ia_bad) begin
									done_q   <= 1'b1;
									status_q <= STS_BAD_INDEX;
								end else begin
									state_q <= ST_READ;
								end
							end
							CMD_REMOVE: begin
								if (ia_bad) begin
									done_q   <= 1'b1;
									status_q <= STS_BAD_INDEX;
								end else begin
									state_q    <= ST_REMOVE;
									rd_pend_s1 <= 1'b1;
									rd_idx_s1  <= ia_x;
									nxt_q      <= ia_x + 1'b1;
								end
							end
							CMD_SWAP: begin
								if (ia_bad || ib_bad) begin
									done_q   <= 1'b1;
									status_q <= STS_BAD_INDEX;
								end else if (ia_x == ib_x) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_SWAP_B;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_READ: begin
					data_q  <= ram_rdata;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_REMOVE: begin
					if (rem_first) begin
						tmp_q <= ram_rdata;
					end
					if (rem_issue) begin
						rd_pend_s1 <= 1'b1;
						rd_idx_s1  <= nxt_q;
						nxt_q      <= nxt_q + 1'b1;
					end else begin
						data_q    <= rem_first ? ram_rdata : tmp_q;
						count_q   <= count_q - 1'b1;
						cnt_out_q <= 7'(count_q - 1'b1);
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_SWAP_B: begin
					tmp_q   <= ram_rdata;
					state_q <= ST_SWAP_WA;
				end
				ST_SWAP_WA: begin
					state_q <= ST_SWAP_WB;
				end
				ST_SWAP_WB: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign data_out = data_q;
	assign status   = status_q;
	assign count    = cnt_out_q;

endmodule

`default_nettype wire

>>> rtl/ile_checker.sv
// ----------------------------------------------------------------------------
// ile_checker
// Port-level checks on the indexed list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_checker
	import ile_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [31:0] data_out,
	input wire logic [1:0]  status,
	input wire logic [6:0]  count
);

	// a result never shows while a request is still running
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe while busy");

	// an accepted request either finishes at once or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted request neither finished nor busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STS_OK || status == STS_BAD_INDEX || status == STS_FULL))
		else $error("undefined status code");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STS_FULL) |-> (count == 7'(DEPTH)))
		else $error("full status with count below depth");

	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STS_OK) |-> (data_out == '0))
		else $error("data returned on a refused request");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.data_out (data_out),
	.status   (status),
	.count    (count)
);

`default_nettype wire

>>> test/ile_list_checker.sv
// ----------------------------------------------------------------------------
// ile_list_checker
// Watches the request and result channels of the indexed list engine, keeps
// its own copy of the list, and compares every result against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ile_list_checker
	import ile_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  cmd,
	input  logic [31:0] value,
	input  logic [5:0]  index_a,
	input  logic [5:0]  index_b,
	input  logic        done,
	input  logic [31:0] data_out,
	input  logic [1:0]  status,
	input  logic [6:0]  count,
	output int          mismatches,
	output int          backlog,
	output int          results_seen,
	output int          full_refusals,
	output int          bad_index_hits
);

	typedef struct packed {
		logic [31:0] data;
		ile_status_t st;
		logic [6:0]  cnt;
	} list_result_t;

	logic [31:0]  list_mem [DEPTH];
	logic [6:0]   list_len;
	list_result_t pending_results [$];

	initial begin
		mismatches     = 0;
		backlog        = 0;
		results_seen   = 0;
		full_refusals  = 0;
		bad_index_hits = 0;
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endtask

	// Apply one request to the list copy and return the result it must produce.
	task automatic apply_request(input logic [2:0] op, input logic [31:0] val,
			input logic [5:0] ia, input logic [5:0] ib, output list_result_t res);
		logic [31:0] held;
		int k;
		res.data = '0;
		res.st   = STS_OK;
		case (op)
			CMD_ADD_FRONT: begin
				if (list_len >= DEPTH) begin
					res.st = STS_FULL;
				end else begin
					for (k = int'(list_len); k > 0; k--) begin
						list_mem[k] = list_mem[k-1];
					end
					list_mem[0] = val;
					list_len++;
				end
			end
			CMD_ADD_BACK: begin
				if (list_len >= DEPTH) begin
					res.st = STS_FULL;
				end else begin
					list_mem[list_len] = val;
					list_len++;
				end
			end
			CMD_READ: begin
				if (ia >= list_len) begin
					res.st = STS_BAD_INDEX;
				end else begin
					res.data = list_mem[ia];
				end
			end
			CMD_REMOVE: begin
				if (ia >= list_len) begin
					res.st = STS_BAD_INDEX;
				end else begin
					res.data = list_mem[ia];
					// close up the entries behind the removed one
					for (k = int'(ia); k < int'(list_len) - 1; k++) begin
						list_mem[k] = list_mem[k+1];
					end
					list_len--;
				end
			end
			CMD_SWAP: begin
				if (ia >= list_len || ib >= list_len) begin
					res.st = STS_BAD_INDEX;
				end else if (ia != ib) begin
					held         = list_mem[ia];
					list_mem[ia] = list_mem[ib];
					list_mem[ib] = held;
				end
			end
			default: begin
			end
		endcase
		res.cnt = list_len;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		list_result_t want;
		list_result_t got;
		if (!arst_n) begin
			list_len = '0;
			pending_results.delete();
			backlog <= 0;
		end else begin
			if (done) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					note_mismatch($sformatf("result with no request pending: data %08h status %0d count %0d",
						data_out, status, count));
				end else begin
					want = pending_results.pop_front();
					if (data_out !== want.data || status !== want.st || count !== want.cnt) begin
						note_mismatch($sformatf(
							"data %08h/%08h status %0d/%0d count %0d/%0d (expected/actual)",
							want.data, data_out, want.st, status, want.cnt, count));
					end
				end
			end
			if (start && !busy) begin
				apply_request(cmd, value, index_a, index_b, got);
				if (got.st == STS_FULL) begin
					full_refusals++;
				end
				if (got.st == STS_BAD_INDEX) begin
					bad_index_hits++;
				end
				pending_results.push_back(got);
			end
			backlog <= pending_results.size();
		end
	end

endmodule

>>> test/tb_indexed_list_engine.sv
// ----------------------------------------------------------------------------
// tb_indexed_list_engine
// Drives directed and random list commands into the indexed list engine under
// several sender idle profiles; a checker beside the block scores the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_indexed_list_engine;
	import ile_pkg::*;

	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
	localparam int         CYCLE_LIMIT      = 500000;
	localparam int         PHASE_ITEMS      = 210;
	localparam int         DRAIN_LIMIT      = 2000;
	localparam int         SETTLE_CYCLES    = 80;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic [2:0]  cmd     = '0;
	logic [31:0] value   = '0;
	logic [5:0]  index_a = '0;
	logic [5:0]  index_b = '0;
	logic        busy;
	logic        done;
	logic [31:0] data_out;
	logic [1:0]  status;
	logic [6:0]  count;

	int mismatches;
	int backlog;
	int results_seen;
	int full_refusals;
	int bad_index_hits;

	int            cycles = 0;
	int            requests = 0;
	int            fill_level = 0;
	int            peak_level = 0;
	traffic_mode_t mode = MODE_FILL;
	int            idle_profile [4] = '{0, 87, 32, 0};

	always #5 clk = ~clk;

	indexed_list_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.value    (value),
		.index_a  (index_a),
		.index_b  (index_b),
		.done     (done),
		.data_out (data_out),
		.status   (status),
		.count    (count)
	);

	ile_list_checker u_list_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.value          (value),
		.index_a        (index_a),
		.index_b        (index_b),
		.done           (done),
		.data_out       (data_out),
		.status         (status),
		.count          (count),
		.mismatches     (mismatches),
		.backlog        (backlog),
		.results_seen   (results_seen),
		.full_refusals  (full_refusals),
		.bad_index_hits (bad_index_hits)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it.
	task automatic issue(input logic [2:0] op, input logic [31:0] val,
			input logic [5:0] ia, input logic [5:0] ib);
		start   <= 1'b1;
		cmd     <= op;
		value   <= val;
		index_a <= ia;
		index_b <= ib;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		requests++;
		case (op)
			CMD_ADD_FRONT, CMD_ADD_BACK: begin
				if (fill_level < DEPTH) begin
					fill_level++;
				end
			end
			CMD_REMOVE: begin
				if (int'(ia) < fill_level) begin
					fill_level--;
				end
			end
			default: begin
			end
		endcase
		if (fill_level > peak_level) begin
			peak_level = fill_level;
		end
	endtask

	task automatic pause_sender(input int idle_pct);
		while (int'($urandom_range(99)) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Hold off until every issued request has returned its result, giving up at DRAIN_LIMIT.
	task automatic wait_drained();
		int w;
		start <= 1'b0;
		@(posedge clk);
		for (w = 0; w < DRAIN_LIMIT && backlog != 0; w++) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [5:0] pick_index();
		if (fill_level != 0 && $urandom_range(9) != 0) begin
			return 6'($urandom_range(fill_level - 1));
		end
		return 6'($urandom_range(63));
	endfunction

	task automatic random_request(input int idle_pct);
		int          roll;
		int          t_front;
		int          t_back;
		int          t_read;
		int          t_remove;
		logic [2:0]  op;
		logic [31:0] val;
		logic [5:0]  ia;
		logic [5:0]  ib;
		// swing between filling to the top and draining to empty, with an occasional mixed phase
		if (fill_level == DEPTH && $urandom_range(9) < 3) begin
			mode = MODE_DRAIN;
		end else if (fill_level == 0 && mode == MODE_DRAIN && $urandom_range(9) < 3) begin
			mode = MODE_FILL;
		end else if ($urandom_range(99) == 0) begin
			mode = MODE_MIXED;
		end
		case (mode)
			MODE_FILL: begin
				t_front = 35; t_back = 70; t_read = 80; t_remove = 85;
			end
			MODE_DRAIN: begin
				t_front = 10; t_back = 20; t_read = 30; t_remove = 80;
			end
			default: begin
				t_front = 20; t_back = 40; t_read = 60; t_remove = 80;
			end
		endcase
		roll = $urandom_range(99);
		if (roll < t_front) begin
			op = CMD_ADD_FRONT;
		end else if (roll < t_back) begin
			op = CMD_ADD_BACK;
		end else if (roll < t_read) begin
			op = CMD_READ;
		end else if (roll < t_remove) begin
			op = CMD_REMOVE;
		end else if (roll < 98) begin
			op = CMD_SWAP;
		end else begin
			op = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
		end
		case ($urandom_range(9))
			0: val = '0;
			1: val = '1;
			default: val = $urandom;
		endcase
		ia = pick_index();
		ib = ($urandom_range(6) == 0) ? ia : pick_index();
		issue(op, val, ia, ib);
		pause_sender(idle_pct);
	endtask

	initial begin
		int p;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty list: every indexed access is refused
		issue(CMD_READ,      32'h0, 6'd0,  6'd0);
		issue(CMD_REMOVE,    32'h0, 6'd0,  6'd0);
		issue(CMD_SWAP,      32'h0, 6'd0,  6'd0);
		issue(CMD_ADD_BACK,  32'hFFFF_FFFF, 6'd63, 6'd63);
		issue(CMD_ADD_FRONT, 32'h0000_0000, 6'd0,  6'd0);
		issue(CMD_ADD_BACK,  32'hA5A5_A5A5, 6'd0,  6'd0);
		issue(CMD_ADD_FRONT, 32'h5A5A_5A5A, 6'd0,  6'd0);
		issue(CMD_READ,      32'h0, 6'd0,  6'd0);
		issue(CMD_READ,      32'h0, 6'd3,  6'd0);
		issue(CMD_READ,      32'h0, 6'd4,  6'd0);
		issue(CMD_READ,      32'h0, 6'd63, 6'd0);
		issue(CMD_SWAP,      32'h0, 6'd0,  6'd3);
		issue(CMD_SWAP,      32'h0, 6'd1,  6'd1);
		issue(CMD_SWAP,      32'h0, 6'd2,  6'd63);
		issue(CMD_SWAP,      32'h0, 6'd63, 6'd2);
		issue(CMD_UNUSED_FIRST, 32'hFFFF_FFFF, 6'd63, 6'd63);
		issue(CMD_UNUSED_LAST,  32'h0, 6'd0,  6'd0);
		issue(CMD_REMOVE,    32'h0, 6'd3,  6'd0);
		issue(CMD_REMOVE,    32'h0, 6'd0,  6'd0);
		issue(CMD_REMOVE,    32'h0, 6'd5,  6'd0);
		issue(CMD_READ,      32'h0, 6'd1,  6'd0);
		issue(CMD_REMOVE,    32'h0, 6'd1,  6'd0);

		for (p = 0; p < 4; p++) begin
			wait_drained();
			mode = MODE_FILL;
			repeat (PHASE_ITEMS) random_request(idle_profile[p]);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d requests and %0d results over four sender idle profiles,",
			requests, results_seen);
		$display("with %0d full-store refusals, %0d bad-index results, peak fill %0d.",
			full_refusals, bad_index_hits, peak_level);
		if (backlog != 0) begin
			$display("%0d results never arrived", backlog);
		end
		if (mismatches == 0 && backlog == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
